/* rtl/core/slt_pkg.sv */
// slt_pkg: shared types, token kind codes and byte classes for the shell line tokenizer.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package slt_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_WORD   = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_DOUBLE = 2'd2;
    localparam logic [1:0] KIND_MARK   = 2'd3;

    localparam logic [7:0] CH_AMP   = 8'h26;  // &
    localparam logic [7:0] CH_PIPE  = 8'h7C;  // |
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ;
    localparam logic [7:0] CH_LT    = 8'h3C;  // <
    localparam logic [7:0] CH_GT    = 8'h3E;  // >
    localparam logic [7:0] CH_UNDER = 8'h5F;  // _

    // One outgoing token character.
    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] kind;
        logic       first;
        logic       last;
        logic       done;
        logic       run;
    } result_t;

    // All results caused by one input character (one or two).
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } bundle_t;

    function automatic logic is_word_byte(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
            (c >= 8'h41 && c <= 8'h5A))
        begin
            hit = 1'b1;
        end
        else
        begin
            unique case (c)
                8'h2E, 8'h27, 8'h2C, 8'h2F, 8'h2D, CH_UNDER, 8'h3A,   // . ' , / - _ :
                8'h7B, 8'h7D, 8'h28, 8'h29, 8'h3F, 8'h23, 8'h24,      // { } ( ) ? # $
                8'h40, 8'h21, 8'h60, 8'h7E, 8'h2B, 8'h3D, 8'h22,      // @ ! ` ~ + = "
                8'h2A, 8'h25, 8'h5E:                                  // * % ^
                    hit = 1'b1;
                default:
                    hit = 1'b0;
            endcase
        end
        return hit;
    endfunction

    function automatic logic is_pair_op(input logic [7:0] c);
        return (c == CH_AMP) || (c == CH_PIPE);
    endfunction

    function automatic logic is_plain_op(input logic [7:0] c);
        return (c == CH_LT) || (c == CH_GT) || (c == CH_SEMI);
    endfunction

endpackage

/* rtl/core/slt_front.sv */
// slt_front: accepts characters, classifies them against the held character and
// builds the one or two results each one causes. Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_char,
    input  logic             line_end,
    input  logic             q_full,
    output logic             push,
    output slt_pkg::bundle_t push_data
);
    import slt_pkg::*;

    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_char_reg, held_char_next;
    logic [1:0] held_kind_reg, held_kind_next;
    logic       held_first_reg, held_first_next;

    logic       accept;
    logic       is_w, is_p, is_o;
    logic [1:0] n;
    result_t    r0, r1, op_res, flush_res;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        is_w = is_word_byte(in_char);
        is_p = is_pair_op(in_char);
        is_o = is_plain_op(in_char);
        n    = 2'd0;
        r0   = '0;
        r1   = '0;
        op_res    = '{ch: in_char, kind: KIND_SINGLE, first: 1'b1, last: 1'b1,
                      done: 1'b0, run: 1'b0};
        flush_res = '0;

        held_valid_next = held_valid_reg;
        held_char_next  = held_char_reg;
        held_kind_next  = held_kind_reg;
        held_first_next = held_first_reg;

        if (!held_valid_reg)
        begin
            held_valid_next = is_w || is_p;
            held_char_next  = in_char;
            held_kind_next  = is_w ? KIND_WORD : KIND_SINGLE;
            held_first_next = 1'b1;
            if (is_o)
            begin
                r0 = op_res;
                n  = 2'd1;
            end
        end
        else if (held_kind_reg == KIND_WORD)
        begin
            r0 = '{ch: held_char_reg, kind: KIND_WORD, first: held_first_reg,
                   last: !is_w, done: 1'b0, run: 1'b0};
            n  = 2'd1;
            held_char_next = in_char;
            if (is_w)
            begin
                held_valid_next = 1'b1;
                held_kind_next  = KIND_WORD;
                held_first_next = 1'b0;
            end
            else
            begin
                held_valid_next = is_p;
                held_kind_next  = KIND_SINGLE;
                held_first_next = 1'b1;
                if (is_o)
                begin
                    r1 = op_res;
                    n  = 2'd2;
                end
            end
        end
        else if (in_char == held_char_reg)
        begin
            // && or || pairs; the pair is complete, nothing stays held
            r0 = '{ch: held_char_reg, kind: KIND_DOUBLE, first: 1'b1, last: 1'b0,
                   done: 1'b0, run: 1'b0};
            r1 = '{ch: in_char, kind: KIND_DOUBLE, first: 1'b0, last: 1'b1,
                   done: 1'b0, run: 1'b0};
            n  = 2'd2;
            held_valid_next = 1'b0;
        end
        else
        begin
            r0 = '{ch: held_char_reg, kind: KIND_SINGLE, first: 1'b1, last: 1'b1,
                   done: 1'b0, run: 1'b0};
            n  = 2'd1;
            held_valid_next = is_w || is_p;
            held_char_next  = in_char;
            held_kind_next  = is_w ? KIND_WORD : KIND_SINGLE;
            held_first_next = 1'b1;
            if (is_o)
            begin
                r1 = op_res;
                n  = 2'd2;
            end
        end

        if (line_end)
        begin
            // flush whatever is held; never more than one result exists here
            if (held_valid_next)
            begin
                flush_res = '{ch: held_char_next, kind: held_kind_next,
                              first: held_first_next, last: 1'b1, done: 1'b0, run: 1'b0};
                if (n == 2'd0)
                begin
                    r0 = flush_res;
                end
                else
                begin
                    r1 = flush_res;
                end
                n = n + 2'd1;
                held_valid_next = 1'b0;
            end
            held_char_next  = '0;
            held_kind_next  = KIND_WORD;
            held_first_next = 1'b0;
            if (n == 2'd0)
            begin
                r0 = '{ch: 8'd0, kind: KIND_MARK, first: 1'b0, last: 1'b0,
                       done: 1'b0, run: 1'b0};
                n  = 2'd1;
            end
            if (n == 2'd2)
            begin
                r1.done = 1'b1;
            end
            else
            begin
                r0.done = 1'b1;
            end
        end

        if (n == 2'd2)
        begin
            r1.run = 1'b1;
        end
        else
        begin
            r0.run = 1'b1;
        end

        push      = accept && (n != 2'd0);
        push_data = '{two: (n == 2'd2), r0: r0, r1: r1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_char_reg  <= '0;
            held_kind_reg  <= KIND_WORD;
            held_first_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_valid_reg <= held_valid_next;
            held_char_reg  <= held_char_next;
            held_kind_reg  <= held_kind_next;
            held_first_reg <= held_first_next;
        end
    end

endmodule

/* rtl/core/slt_fifo.sv */
// slt_fifo: short queue of result bundles between the front and back parts.
// Depends on slt_pkg for the bundle type.
`timescale 1ns / 1ps

module slt_fifo #(
    parameter int DEPTH = slt_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  slt_pkg::bundle_t           push_data,
    input  logic                       pop,
    output slt_pkg::bundle_t           pop_data,
    output logic                       full,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import slt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/slt_back.sv */
// slt_back: drains result bundles from the queue one character per transfer
// into the output register. Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  slt_pkg::bundle_t q_data,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_char,
    output logic [1:0]       token_kind,
    output logic             token_first,
    output logic             token_last,
    output logic             line_done,
    output logic             run_last
);
    import slt_pkg::*;

    logic    slot_reg, slot_next;     // 1: second result of the head bundle is next
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    result_t cur;
    logic    load;

    assign cur  = slot_reg ? q_data.r1 : q_data.r0;
    assign load = q_valid && (!out_valid_reg || out_ready);
    assign pop  = load && (slot_reg || !q_data.two);

    always_comb
    begin
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load)
        begin
            out_next       = cur;
            out_valid_next = 1'b1;
            slot_next      = q_data.two && !slot_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_reg.ch;
    assign token_kind  = out_reg.kind;
    assign token_first = out_reg.first;
    assign token_last  = out_reg.last;
    assign line_done   = out_reg.done;
    assign run_last    = out_reg.run;

endmodule

/* rtl/core/shell_line_tokenizer.sv */
// shell_line_tokenizer: top level of the streaming command line tokenizer.
// Depends on slt_pkg, slt_front, slt_fifo and slt_back.
//
// Usage: one byte of the command line is a transfer on the input channel
// (in_valid/in_ready, in_char, line_end marks the last byte of a line).
// Token characters leave as transfers on the output channel (out_valid/
// out_ready) with token_kind, token_first/token_last, line_done on the final
// result of a line and run_last on the last result caused by one input byte.
// Words and lone & or | are held for one byte so the next byte can end the
// token or pair it into && or ||; a line end flushes what is held or sends a
// bare marker (kind 3, out_char 0).
// Each result is registered in the bundle queue and then in the output register.
// Throughput: one byte per cycle while the queue is not full; a byte causes at
// most two results and the output moves one per cycle, so the bundle queue
// between front and back (Q_DEPTH entries) absorbs the second result. in_ready
// drops only when that queue is full. When the receiver stalls, the output
// register holds and the queue fills, after which input stalls too. Reset
// empties the queue, clears the held character and drops out_valid.
`timescale 1ns / 1ps

module shell_line_tokenizer #(
    parameter int Q_DEPTH = slt_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic [1:0] token_kind,
    output logic       token_first,
    output logic       token_last,
    output logic       line_done,
    output logic       run_last
);
    import slt_pkg::*;

    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic             push, pop, q_full, q_valid;
    bundle_t          push_data, q_data;
    logic [CNT_W-1:0] q_count;

    // Front: classify each byte against the held one, build its results.
    slt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_char   (in_char),
        .line_end  (line_end),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Queue of result bundles; decouples byte intake from output stalls.
    slt_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (q_data),
        .full      (q_full),
        .not_empty (q_valid),
        .count     (q_count)
    );

    // Back: serialize bundles into single-character transfers.
    slt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .token_kind  (token_kind),
        .token_first (token_first),
        .token_last  (token_last),
        .line_done   (line_done),
        .run_last    (run_last)
    );

`ifndef SYNTHESIS
    // the final result of a line is always the last result of its byte
    a_done_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |-> run_last)
        else $error("line_done without run_last");

    // a bare marker only closes a line and carries no character
    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == KIND_MARK) |->
            line_done && !token_first && !token_last && (out_char == 8'd0))
        else $error("malformed line-end marker");

    // input backpressure comes only from a full queue
    a_ready_tracks_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count <= CNT_W'(Q_DEPTH)) && (in_ready == (q_count != CNT_W'(Q_DEPTH))))
        else $error("queue occupancy and in_ready disagree");

    // a pushed bundle is never dropped at the queue
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("bundle pushed into full queue");
`endif

endmodule

/* bench/slt_token_checker.sv */
// slt_token_checker: watches both channels of the shell line tokenizer, predicts every
// token character from the accepted bytes and compares the results in order.
// Depends on slt_pkg for the result struct and the token kind codes.
`timescale 1ns / 1ps

module slt_token_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       line_end,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_char,
    input  logic [1:0] token_kind,
    input  logic       token_first,
    input  logic       token_last,
    input  logic       line_done,
    input  logic       run_last,
    output int         error_count,
    output int         pending_count
);
    import slt_pkg::*;

    result_t     token_queue[$];
    result_t     step_out[2];
    int          step_n;
    int          errs;

    // Held character, mirrors the block's one-byte lookahead.
    logic        hold_vld;
    logic [7:0]  hold_ch;
    logic [1:0]  hold_kind;
    logic        hold_first;

    function automatic logic word_char(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
        begin
            hit = 1'b1;
        end
        else
        begin
            case (c)
                ".", "'", ",", "/", "-", CH_UNDER, ":", "{", "}", "(", ")", "?", "#", "$",
                "@", "!", 8'h60, "~", "+", "=", "\"", "*", "%", "^":
                    hit = 1'b1;
                default:
                    hit = 1'b0;
            endcase
        end
        return hit;
    endfunction

    task automatic show_result(input string tag, input result_t r);
        $display("%0t %s: ch=%02h kind=%0d f=%0b l=%0b d=%0b r=%0b",
                 $realtime, tag, r.ch, r.kind, r.first, r.last, r.done, r.run);
    endtask

    task automatic put_char(input logic [7:0] ch, input logic [1:0] kind,
                            input logic first, input logic last);
        result_t r;
        r = '0;
        r.ch    = ch;
        r.kind  = kind;
        r.first = first;
        r.last  = last;
        if (step_n < 2)
        begin
            step_out[step_n] = r;
            step_n++;
        end
    endtask

    task automatic hold_char(input logic [7:0] c, input logic [1:0] kind,
                             input logic first);
        hold_vld   = 1'b1;
        hold_ch    = c;
        hold_kind  = kind;
        hold_first = first;
    endtask

    // Byte seen with nothing held.
    task automatic take_fresh(input logic [7:0] c);
        if (word_char(c))
            hold_char(c, KIND_WORD, 1'b1);
        else if (c == CH_AMP || c == CH_PIPE)
            hold_char(c, KIND_SINGLE, 1'b1);
        else if (c == CH_LT || c == CH_GT || c == CH_SEMI)
            put_char(c, KIND_SINGLE, 1'b1, 1'b1);
    endtask

    task automatic tokenize_byte(input logic [7:0] c, input logic le);
        step_n = 0;
        if (!hold_vld)
        begin
            take_fresh(c);
        end
        else if (hold_kind == KIND_WORD)
        begin
            if (word_char(c))
            begin
                put_char(hold_ch, KIND_WORD, hold_first, 1'b0);
                hold_char(c, KIND_WORD, 1'b0);
            end
            else
            begin
                put_char(hold_ch, KIND_WORD, hold_first, 1'b1);
                hold_vld = 1'b0;
                take_fresh(c);
            end
        end
        else
        begin
            hold_vld = 1'b0;
            if (c == hold_ch)
            begin
                put_char(hold_ch, KIND_DOUBLE, 1'b1, 1'b0);
                put_char(c, KIND_DOUBLE, 1'b0, 1'b1);
            end
            else
            begin
                put_char(hold_ch, KIND_SINGLE, 1'b1, 1'b1);
                take_fresh(c);
            end
        end

        if (le)
        begin
            if (hold_vld)
            begin
                put_char(hold_ch, hold_kind, hold_first, 1'b1);
                hold_vld = 1'b0;
            end
            hold_ch    = '0;
            hold_kind  = KIND_WORD;
            hold_first = 1'b0;
            if (step_n == 0)
                put_char(8'h00, KIND_MARK, 1'b0, 1'b0);
            step_out[step_n - 1].done = 1'b1;
        end
        if (step_n > 0)
            step_out[step_n - 1].run = 1'b1;
        for (int i = 0; i < step_n; i++)
            token_queue.push_back(step_out[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            token_queue.delete();
            hold_vld      = 1'b0;
            hold_ch       = '0;
            hold_kind     = KIND_WORD;
            hold_first    = 1'b0;
            errs          = 0;
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                tokenize_byte(in_char, line_end);

            if (out_valid && out_ready)
            begin
                got = {out_char, token_kind, token_first, token_last, line_done, run_last};
                if (token_queue.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        show_result("unexpected transfer", got);
                end
                else
                begin
                    want = token_queue.pop_front();
                    if (got.ch !== want.ch || got.kind !== want.kind ||
                        got.first !== want.first || got.last !== want.last ||
                        got.done !== want.done || got.run !== want.run)
                    begin
                        errs++;
                        if (errs <= 10)
                        begin
                            show_result("mismatch, expected", want);
                            show_result("mismatch, actual  ", got);
                        end
                    end
                end
            end
            error_count   <= errs;
            pending_count <= token_queue.size();
        end
    end

endmodule

/* bench/tb_shell_line_tokenizer.sv */
// tb_shell_line_tokenizer: stimulus and verdict for the shell line tokenizer.
// Depends on slt_pkg, the block under test and slt_token_checker.
`timescale 1ns / 1ps

module tb_shell_line_tokenizer;
    import slt_pkg::*;

    // Receiver behavior, switched per phase.
    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_e;

    localparam int RAND_ITEMS  = 550;
    localparam int HOLD_CYCLES = 200;   // long receiver hold-off, fills the bundle queue
    localparam int DRAIN_LIMIT = 20000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_char   = 8'h00;
    logic       line_end  = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_char;
    logic [1:0] token_kind;
    logic       token_first;
    logic       token_last;
    logic       line_done;
    logic       run_last;

    int         errors;
    int         pending;

    // Sender pacing: bursts of random length, random gaps between them.
    int         burst_left  = 0;
    int         tx_gap_max  = 6;
    int         items_sent  = 0;
    bit         drain_ok    = 1'b1;

    // Receiver controls, owned by the receiver process except for the requests.
    rx_mode_e   rx_mode     = RX_ALWAYS;
    bit         hold_req    = 1'b0;
    int         hold_left   = 0;
    int         rx_cycle    = 0;

    always #6 clk = ~clk;

    shell_line_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_char     (in_char),
        .line_end    (line_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .token_kind  (token_kind),
        .token_first (token_first),
        .token_last  (token_last),
        .line_done   (line_done),
        .run_last    (run_last)
    );

    slt_token_checker u_tokens_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_char       (in_char),
        .line_end      (line_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_char      (out_char),
        .token_kind    (token_kind),
        .token_first   (token_first),
        .token_last    (token_last),
        .line_done     (line_done),
        .run_last      (run_last),
        .error_count   (errors),
        .pending_count (pending)
    );

    // Receiver: a long hold-off on request, otherwise the phase's stall pattern.
    always @(posedge clk)
    begin
        rx_cycle++;
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:  out_ready <= 1'b1;
                RX_COIN:    out_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
                RX_PATTERN: out_ready <= ((rx_cycle % 7) != 2) && ((rx_cycle % 11) != 5);
                default:    out_ready <= 1'b1;
            endcase
        end
    end

    // One byte transfer. Called right after a rising edge; valid stays up within a
    // burst, so only one assignment to in_valid happens per edge.
    task automatic send_byte(input logic [7:0] c, input logic le);
        int gap;
        if (burst_left == 0)
        begin
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        line_end <= le;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Sender pauses until every predicted result has left, or clears drain_ok when
    // DRAIN_LIMIT runs out, then idles before returning.
    task automatic wait_for_results();
        int n;
        n = 0;
        in_valid   <= 1'b0;
        burst_left = 0;
        do
        begin
            @(posedge clk);
            n++;
        end
        while (pending != 0 && n < DRAIN_LIMIT);
        if (pending != 0)
            drain_ok = 1'b0;
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_word_char();
        string punct;
        logic [7:0] c;
        punct = "._-/:,'{}()?#$@!~+=\"*%^";
        case ($urandom_range(0, 4))
            0: c = 8'(8'h61 + $urandom_range(0, 25));
            1: c = 8'(8'h41 + $urandom_range(0, 25));
            2: c = 8'(8'h30 + $urandom_range(0, 9));
            3: c = punct[$urandom_range(0, punct.len() - 1)];
            default: c = ($urandom_range(0, 5) == 0) ? 8'h60 : "z";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_separator();
        string odd;
        logic [7:0] c;
        odd = "[]\\";
        case ($urandom_range(0, 5))
            0, 1: c = " ";
            2: c = 8'h09;
            3: c = 8'(8'h80 + $urandom_range(0, 127));
            4: c = odd[$urandom_range(0, 2)];
            default: c = 8'($urandom_range(0, 31));
        endcase
        return c;
    endfunction

    // Builds and sends one command line: mostly well-formed tokens with random
    // content, some lines of raw noise.
    task automatic send_random_line();
        logic [7:0] line_q[$];
        string      plain_ops;
        int         ntok;
        int         len;
        logic [7:0] op;
        plain_ops   = "<>;";
        if ($urandom_range(0, 9) == 0)
        begin
            len = $urandom_range(1, 10);
            repeat (len) line_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            ntok = $urandom_range(0, 6);
            repeat (ntok)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                    begin
                        len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                          : $urandom_range(1, 6);
                        repeat (len) line_q.push_back(pick_word_char());
                    end
                    5:
                    begin
                        line_q.push_back(plain_ops[$urandom_range(0, 2)]);
                    end
                    6, 7, 8:
                    begin
                        // lone, paired or run of & and |, mixed at random
                        len = $urandom_range(1, 3);
                        op  = $urandom_range(0, 1) ? CH_AMP : CH_PIPE;
                        repeat (len)
                        begin
                            line_q.push_back(op);
                            if ($urandom_range(0, 4) == 0)
                                op = (op == CH_AMP) ? CH_PIPE : CH_AMP;
                        end
                    end
                    default:
                        line_q.push_back(pick_separator());
                endcase
                if ($urandom_range(0, 9) < 6)
                    repeat ($urandom_range(1, 2)) line_q.push_back(pick_separator());
            end
            if (line_q.size() == 0 || $urandom_range(0, 3) == 0)
                line_q.push_back(pick_separator());
        end
        foreach (line_q[i])
            send_byte(line_q[i], i == line_q.size() - 1);
    endtask

    // Hard stop in case the block hangs.
    initial
    begin
        #(12 * 300000);
        $display("tb_shell_line_tokenizer: errors");
        $finish;
    end

    initial
    begin
        int phase_start;
        bit hold_done;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed lines: bare markers, word extremes, operator pairing, separators.
        send_line(" ");                     // empty line gives a bare marker
        send_byte(8'h00, 1'b1);
        send_line("a0Z9z_");
        send_line("&&&;");                  // && then & then ;
        send_line("||x");
        send_line("a&b|c");
        send_line("<>;");
        send_byte("w", 1'b0);
        send_byte("[", 1'b0);               // unlisted punctuation ends the word
        send_byte(8'hFF, 1'b1);             // nothing left, so a marker
        send_line("&");                     // held & flushed at line end
        send_line("&");                     // no pairing across lines
        send_line("x  ");                   // word sent before the end, then marker
        wait_for_results();

        // Random phases, each with its own receiver and sender pacing.
        hold_done = 1'b0;
        for (int p = 0; p < 6; p++)
        begin
            rx_mode     = rx_mode_e'(p % 4);
            tx_gap_max  = (p == 1 || p == 4) ? 0 : 6;
            phase_start = items_sent;
            while (items_sent - phase_start < RAND_ITEMS / 6)
            begin
                if (p == 2 && !hold_done && items_sent - phase_start > 30)
                begin
                    // receiver holds off while the sender keeps offering
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                send_random_line();
            end
            wait_for_results();
        end

        if (drain_ok && errors == 0 && pending == 0)
            $display("tb_shell_line_tokenizer: clean");
        else
            $display("tb_shell_line_tokenizer: errors");
        $finish;
    end

endmodule
